// File: rtl/mtpe_pkg.sv
package mtpe_pkg;

    localparam int HISTORY_DEPTH_DEF = 240;
    localparam int RX_MAX_BYTES_DEF  = 16;
    localparam int EMA_FRAC_BITS_DEF = 8;

    localparam logic [1:0] REQ_POLL = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_HIST = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_HIST = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_SHORT     = 3'd1;
    localparam logic [2:0] STAT_BAD_ADDR  = 3'd2;
    localparam logic [2:0] STAT_BAD_FUNC  = 3'd3;
    localparam logic [2:0] STAT_BAD_COUNT = 3'd4;

    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_REG   = 2'd1;
    localparam logic [1:0] CFG_ALPHA = 2'd2;

    localparam logic [7:0]  SLAVE_RESET = 8'h01;
    localparam logic [15:0] REG_RESET   = 16'h0000;
    localparam logic [15:0] ALPHA_RESET = 16'd9830;

    localparam logic [7:0] FUNC_READ_HOLD  = 8'h03;
    localparam logic [7:0] QTY_HI          = 8'h00;
    localparam logic [7:0] QTY_LO          = 8'h01;
    localparam logic [7:0] RESP_BYTE_COUNT = 8'h02;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int         CAP_DEPTH     = 5;
    localparam int         CAP_AW        = 3;
    localparam int         MIN_FRAME_LEN = 7;
    localparam logic [2:0] POS_CRC_LO    = 3'd6;
    localparam logic [2:0] POS_LAST      = 3'd7;

    localparam logic [15:0] DIV5_MUL    = 16'd52429;
    localparam int          DIV5_SHIFT  = 18;
    localparam int          RECIP_SHIFT = 20;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/modbus_temperature_poller_ema_core.sv
// Modbus RTU temperature poller with a fixed-point moving average. A poll beat
// yields the eight request bytes (read one holding register, CRC low byte first),
// one per cycle as the output takes them. Response bytes are taken one per cycle;
// the last byte of a frame yields one reading outcome once the alpha multiply and
// the divide-by-ten multiply, each registered, are done; a rejected frame skips
// them. A history read yields its entry after the offset reduction and then one
// history memory read, each registered. Other response bytes are taken while a
// job is running; a beat that yields results waits until the running job has
// handed its last result to the output register. After reset the history memory
// is cleared one entry a cycle, all HISTORY_DEPTH entries, while input is stalled.
module modbus_temperature_poller_ema_core #(
    parameter int HISTORY_DEPTH     = mtpe_pkg::HISTORY_DEPTH_DEF,
    parameter int RX_MAX_BYTES      = mtpe_pkg::RX_MAX_BYTES_DEF,
    parameter int EMA_FRACTION_BITS = mtpe_pkg::EMA_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_rx_last,
    input  logic [7:0]         i_history_offset,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_result_kind,
    output logic [7:0]         o_tx_byte,
    output logic               o_tx_last,
    output logic [2:0]         o_read_status,
    output logic signed [15:0] o_raw_tenths,
    output logic signed [15:0] o_ema_tenths,
    output logic signed [12:0] o_history_degrees
);

    localparam int HA        = $clog2(HISTORY_DEPTH);
    localparam int CW        = $clog2(RX_MAX_BYTES + 1);
    localparam int EW        = 16 + EMA_FRACTION_BITS;
    localparam int DW        = EW + 1;
    localparam int PW        = DW + 17;
    localparam int SW        = ((HA > 8) ? HA : 8) + 1;
    localparam int OPW       = 8 + mtpe_pkg::RECIP_SHIFT + 1;
    localparam int OFF_RECIP =
        ((1 << mtpe_pkg::RECIP_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int FRAC_MASK = (1 << EMA_FRACTION_BITS) - 1;

    localparam logic [3:0] JOB_IDLE  = 4'd0;
    localparam logic [3:0] JOB_POLL  = 4'd1;
    localparam logic [3:0] JOB_EMA_A = 4'd2;
    localparam logic [3:0] JOB_EMA_B = 4'd3;
    localparam logic [3:0] JOB_EMA_C = 4'd4;
    localparam logic [3:0] JOB_EMA_D = 4'd5;
    localparam logic [3:0] JOB_EMA_E = 4'd6;
    localparam logic [3:0] JOB_H_REM = 4'd7;
    localparam logic [3:0] JOB_H_ADR = 4'd8;
    localparam logic [3:0] JOB_H_OUT = 4'd9;

    logic [7:0]  r_slave;
    logic [15:0] r_regaddr;
    logic [15:0] r_alpha;

    logic [CW-1:0] r_rx_count;
    logic [CW-1:0] rx_count_inc;
    logic [7:0]    r_cap [mtpe_pkg::CAP_DEPTH];

    logic [3:0]  r_job;
    logic [2:0]  r_tx_idx;
    logic [15:0] r_crc;
    logic [7:0]  tx_byte;

    logic [2:0]        r_status;
    logic [2:0]        n_status;
    logic signed [15:0] r_raw;

    logic signed [EW-1:0] r_ema;
    logic signed [EW-1:0] raw_scaled;
    logic                 r_seed;
    logic signed [DW-1:0] r_diff;
    logic signed [PW-1:0] r_prod;
    logic signed [EW+2:0] ema_sum;
    logic [EW-1:0]        ema_abs;
    logic                 r_div_sign;
    logic [30:0]          r_div_prod;
    logic [12:0]          div_q;
    logic signed [12:0]   hist_val;
    logic [EW:0]          ema_bias;
    logic signed [EW:0]   ema_rnd;
    logic signed [15:0]   ema_tenths;

    logic [HA-1:0]  r_wr_pos;
    logic [HA-1:0]  r_clr_idx;
    logic           r_clr_busy;
    logic [7:0]     r_off;
    logic [OPW-1:0] r_off_prod;
    logic [7:0]     off_q;
    logic [19:0]    off_qd;
    logic [7:0]     r_rem;
    logic [SW-1:0]  slot_sum;
    logic [HA-1:0]  slot;

    logic [12:0]   r_hist_mem [HISTORY_DEPTH];
    logic [12:0]   r_hist_q;
    logic          mem_we;
    logic          mem_re;
    logic [HA-1:0] mem_waddr;
    logic [12:0]   mem_wdata;

    logic in_has_result;
    logic in_acc;

    logic               out_free;
    logic               out_load;
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [7:0]         r_out_tx;
    logic               r_out_last;
    logic [2:0]         r_out_status;
    logic signed [15:0] r_out_raw;
    logic signed [15:0] r_out_ema;
    logic signed [12:0] r_out_hist;
    logic [1:0]         n_out_kind;
    logic [7:0]         n_out_tx;
    logic               n_out_last;
    logic [2:0]         n_out_status;
    logic signed [15:0] n_out_raw;
    logic signed [15:0] n_out_ema;
    logic signed [12:0] n_out_hist;

    // input handshake
    always_comb begin
        in_has_result = (i_req_type == mtpe_pkg::REQ_POLL)
                     || (i_req_type == mtpe_pkg::REQ_HIST)
                     || ((i_req_type == mtpe_pkg::REQ_BYTE) && i_rx_last);
        o_in_stall = r_clr_busy || ((r_job != JOB_IDLE) && in_has_result);
    end

    assign in_acc = i_in_valid && !o_in_stall;

    // frame check
    assign rx_count_inc = (r_rx_count < CW'(RX_MAX_BYTES)) ? (r_rx_count + CW'(1)) : r_rx_count;

    always_comb begin
        if (rx_count_inc < CW'(mtpe_pkg::MIN_FRAME_LEN)) begin
            n_status = mtpe_pkg::STAT_SHORT;
        end else if (r_cap[0] != r_slave) begin
            n_status = mtpe_pkg::STAT_BAD_ADDR;
        end else if (r_cap[1] != mtpe_pkg::FUNC_READ_HOLD) begin
            n_status = mtpe_pkg::STAT_BAD_FUNC;
        end else if (r_cap[2] != mtpe_pkg::RESP_BYTE_COUNT) begin
            n_status = mtpe_pkg::STAT_BAD_COUNT;
        end else begin
            n_status = mtpe_pkg::STAT_OK;
        end
    end

    // request frame
    always_comb begin
        case (r_tx_idx)
            3'd0:    tx_byte = r_slave;
            3'd1:    tx_byte = mtpe_pkg::FUNC_READ_HOLD;
            3'd2:    tx_byte = r_regaddr[15:8];
            3'd3:    tx_byte = r_regaddr[7:0];
            3'd4:    tx_byte = mtpe_pkg::QTY_HI;
            3'd5:    tx_byte = mtpe_pkg::QTY_LO;
            3'd6:    tx_byte = r_crc[7:0];
            default: tx_byte = r_crc[15:8];
        endcase
    end

    // average arithmetic
    always_comb begin
        raw_scaled = EW'(r_raw) <<< EMA_FRACTION_BITS;
        ema_sum    = (EW+3)'(r_ema) + (EW+3)'(r_prod >>> 16);
        ema_abs    = r_ema[EW-1] ? EW'(-r_ema) : EW'(r_ema);
        div_q      = r_div_prod[mtpe_pkg::DIV5_SHIFT +: 13];
        hist_val   = r_div_sign ? -$signed(div_q) : $signed(div_q);
        ema_bias   = r_ema[EW-1] ? (EW+1)'(FRAC_MASK) : '0;
        ema_rnd    = (EW+1)'(r_ema) + $signed(ema_bias);
        ema_tenths = 16'(ema_rnd >>> EMA_FRACTION_BITS);
    end

    // history slot
    always_comb begin
        off_q    = r_off_prod[mtpe_pkg::RECIP_SHIFT +: 8];
        off_qd   = 20'(off_q) * 20'(HISTORY_DEPTH);
        slot_sum = SW'(r_wr_pos) + SW'(r_rem);
        slot     = (slot_sum >= SW'(HISTORY_DEPTH)) ? HA'(slot_sum - SW'(HISTORY_DEPTH))
                                                    : HA'(slot_sum);
    end

    // memory port control and output load
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_wr_pos;
        mem_wdata    = hist_val;
        mem_re       = (r_job == JOB_H_ADR);
        out_load     = 1'b0;
        n_out_kind   = mtpe_pkg::KIND_TX;
        n_out_tx     = '0;
        n_out_last   = 1'b0;
        n_out_status = mtpe_pkg::STAT_OK;
        n_out_raw    = '0;
        n_out_ema    = '0;
        n_out_hist   = '0;
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end
        case (r_job)
            JOB_POLL: begin
                out_load   = out_free;
                n_out_kind = mtpe_pkg::KIND_TX;
                n_out_tx   = tx_byte;
                n_out_last = (r_tx_idx == mtpe_pkg::POS_LAST);
            end
            JOB_EMA_A: begin
                out_load     = out_free && (r_status != mtpe_pkg::STAT_OK);
                n_out_kind   = mtpe_pkg::KIND_READ;
                n_out_status = r_status;
                n_out_ema    = ema_tenths;
            end
            JOB_EMA_E: begin
                out_load     = out_free;
                mem_we       = out_free;
                n_out_kind   = mtpe_pkg::KIND_READ;
                n_out_status = mtpe_pkg::STAT_OK;
                n_out_raw    = r_raw;
                n_out_ema    = ema_tenths;
            end
            JOB_H_OUT: begin
                out_load   = out_free;
                n_out_kind = mtpe_pkg::KIND_HIST;
                n_out_hist = r_hist_q;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave     <= mtpe_pkg::SLAVE_RESET;
            r_regaddr   <= mtpe_pkg::REG_RESET;
            r_alpha     <= mtpe_pkg::ALPHA_RESET;
            r_rx_count  <= '0;
            r_job       <= JOB_IDLE;
            r_tx_idx    <= '0;
            r_crc       <= mtpe_pkg::CRC_INIT;
            r_ema       <= '0;
            r_wr_pos    <= '0;
            r_clr_idx   <= '0;
            r_clr_busy  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mtpe_pkg::CFG_SLAVE: r_slave   <= i_cfg_data[7:0];
                    mtpe_pkg::CFG_REG:   r_regaddr <= i_cfg_data;
                    mtpe_pkg::CFG_ALPHA: r_alpha   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_clr_busy) begin
                if (r_clr_idx == HA'(HISTORY_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                    r_clr_idx  <= '0;
                end else begin
                    r_clr_idx <= r_clr_idx + HA'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_job)
                JOB_IDLE: begin
                end
                JOB_POLL: begin
                    if (out_load) begin
                        r_tx_idx <= r_tx_idx + 3'd1;
                        if (r_tx_idx < mtpe_pkg::POS_CRC_LO) begin
                            r_crc <= mtpe_pkg::crc16_byte(r_crc, tx_byte);
                        end
                        if (r_tx_idx == mtpe_pkg::POS_LAST) begin
                            r_job <= JOB_IDLE;
                        end
                    end
                end
                JOB_EMA_A: begin
                    if (r_status == mtpe_pkg::STAT_OK) begin
                        r_job <= JOB_EMA_B;
                    end else if (out_load) begin
                        r_job <= JOB_IDLE;
                    end
                end
                JOB_EMA_B: r_job <= JOB_EMA_C;
                JOB_EMA_C: begin
                    r_ema <= r_seed ? raw_scaled : ema_sum[EW-1:0];
                    r_job <= JOB_EMA_D;
                end
                JOB_EMA_D: r_job <= JOB_EMA_E;
                JOB_EMA_E: begin
                    if (out_load) begin
                        r_wr_pos <= (r_wr_pos == HA'(HISTORY_DEPTH - 1)) ? '0
                                                                          : (r_wr_pos + HA'(1));
                        r_job    <= JOB_IDLE;
                    end
                end
                JOB_H_REM: r_job <= JOB_H_ADR;
                JOB_H_ADR: r_job <= JOB_H_OUT;
                JOB_H_OUT: begin
                    if (out_load) begin
                        r_job <= JOB_IDLE;
                    end
                end
                default: r_job <= JOB_IDLE;
            endcase

            if (in_acc) begin
                unique case (i_req_type)
                    mtpe_pkg::REQ_POLL: begin
                        r_rx_count <= '0;
                        r_tx_idx   <= '0;
                        r_crc      <= mtpe_pkg::CRC_INIT;
                        r_job      <= JOB_POLL;
                    end
                    mtpe_pkg::REQ_BYTE: begin
                        if (i_rx_last) begin
                            r_rx_count <= '0;
                            r_job      <= JOB_EMA_A;
                        end else begin
                            r_rx_count <= rx_count_inc;
                        end
                    end
                    mtpe_pkg::REQ_HIST: r_job <= JOB_H_REM;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == mtpe_pkg::REQ_BYTE)) begin
            if (r_rx_count < CW'(mtpe_pkg::CAP_DEPTH)) begin
                r_cap[r_rx_count[mtpe_pkg::CAP_AW-1:0]] <= i_rx_byte;
            end
            if (i_rx_last) begin
                r_status <= n_status;
                r_raw    <= $signed({r_cap[3], r_cap[4]});
            end
        end
        if (in_acc && (i_req_type == mtpe_pkg::REQ_HIST)) begin
            r_off      <= i_history_offset;
            r_off_prod <= OPW'(i_history_offset) * OPW'(OFF_RECIP);
        end
        if (r_job == JOB_H_REM) begin
            r_rem <= r_off - off_qd[7:0];
        end
        if (r_job == JOB_EMA_A) begin
            r_seed <= (r_ema == '0);
            r_diff <= DW'(raw_scaled) - DW'(r_ema);
        end
        if (r_job == JOB_EMA_B) begin
            r_prod <= PW'($signed({1'b0, r_alpha})) * PW'(r_diff);
        end
        if (r_job == JOB_EMA_D) begin
            r_div_sign <= r_ema[EW-1];
            r_div_prod <= 31'(ema_abs[EW-1:EMA_FRACTION_BITS+1]) * 31'(mtpe_pkg::DIV5_MUL);
        end
        if (out_load) begin
            r_out_kind   <= n_out_kind;
            r_out_tx     <= n_out_tx;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
            r_out_raw    <= n_out_raw;
            r_out_ema    <= n_out_ema;
            r_out_hist   <= n_out_hist;
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_hist_q <= r_hist_mem[slot];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_tx_byte         = r_out_tx;
    assign o_tx_last         = r_out_last;
    assign o_read_status     = r_out_status;
    assign o_raw_tenths      = r_out_raw;
    assign o_ema_tenths      = r_out_ema;
    assign o_history_degrees = r_out_hist;

    a_poll_beats_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == mtpe_pkg::KIND_TX) && !r_out_last)
            |-> (r_job == JOB_POLL))
        else $error("request beat shown without a running poll");

    a_ring_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job == JOB_EMA_E) |-> (r_status == mtpe_pkg::STAT_OK))
        else $error("ring write for a rejected frame");

    a_wr_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos <= HA'(HISTORY_DEPTH - 1))
        else $error("write position out of range");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> ((r_job == JOB_IDLE) && !r_out_valid))
        else $error("activity during history clear");

endmodule
